>>> rtl/video_test_pattern_generator_core_macros.svh
// ----------------------------------------------------------------------------
// video test pattern generator assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH

// condition implies a fact in the same cycle
`define VTPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtpg assertion failed");

// condition implies a fact in the next cycle
`define VTPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtpg assertion failed");

`endif

>>> rtl/vtpg_pkg.sv
// ----------------------------------------------------------------------------
// vtpg_pkg
// types, codes and geometry constants of the video test pattern generator
// ----------------------------------------------------------------------------
package vtpg_pkg;

  localparam int unsigned ScreenWidth  = 240;
  localparam int unsigned ScreenHeight = 160;

  localparam int unsigned CmdW   = 1;
  localparam int unsigned KeysW  = 7;
  localparam int unsigned CoordW = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned BarW   = 3;
  localparam int unsigned GreyW  = 5;
  localparam int unsigned PanelW = 3;
  localparam int unsigned FrameW = 5;
  localparam int unsigned HoldW  = 8;

  // apb register map
  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-1:0] AddrPanelHold = 2'd0;
  localparam logic [HoldW-1:0]  HoldReset     = 8'd128;

  // key masks: a, right, r step forward; b, left, l step back
  localparam logic [KeysW-1:0] KeysFwd   = 7'h29;
  localparam logic [KeysW-1:0] KeysBack  = 7'h16;
  localparam int unsigned      KeyStart  = 6;

  // picture geometry
  localparam logic [CoordW-1:0] AreaTop   = 8'd8;
  localparam logic [CoordW-1:0] AreaBot   = 8'd136;
  localparam logic [CoordW-1:0] BarsRows  = 8'd90;
  localparam logic [CoordW-1:0] DimRow    = 8'd137;
  localparam logic [CoordW-1:0] BandTop   = 8'd138;
  localparam logic [CoordW-1:0] BandEnd   = 8'd150;
  localparam logic [CoordW-1:0] XLast     = 8'd239;
  localparam logic [CoordW-1:0] YLast     = 8'd159;
  localparam logic [CoordW-1:0] XMid      = 8'd120;
  localparam logic [CoordW-1:0] XHalfIn   = 8'd80;
  localparam logic [CoordW-1:0] XHalfOut  = 8'd160;
  localparam logic [CoordW-1:0] HatchRow  = 8'd135;
  localparam logic [CoordW-1:0] CrossTop  = 8'd48;
  localparam logic [CoordW-1:0] CrossEnd  = 8'd72;
  localparam logic [CoordW-1:0] CrossLeft = 8'd96;
  localparam logic [CoordW-1:0] CrossRite = 8'd144;
  localparam logic [CoordW-1:0] SwatchTop = 8'd116;
  localparam logic [CoordW-1:0] SwatchEnd = 8'd134;

  // x/15 as (x*137)>>11, exact for x below 256
  localparam logic [CoordW-1:0] Div15Mul   = 8'd137;
  // x*31/239 as (x*272025)>>21, exact for x below 240
  localparam logic [18:0]       RampMul    = 19'd272025;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_BLACK = 3'd0,
    KIND_WHITE = 3'd1,
    KIND_RED   = 3'd2,
    KIND_BLUE  = 3'd3,
    KIND_DIM   = 3'd4,
    KIND_BAR   = 3'd5,
    KIND_GREY  = 3'd6
  } kind_e;

  typedef enum logic [PanelW-1:0] {
    CARD_BARS  = 3'd0,
    CARD_HATCH = 3'd1,
    CARD_BURST = 3'd2,
    CARD_CHECK = 3'd3,
    CARD_EDGE  = 3'd4
  } panel_e;

  // sequencer state seen by the pixel classifier
  typedef struct packed {
    panel_e            panel;
    logic [FrameW-1:0] frame_low;
  } view_t;

  function automatic panel_e panel_next(panel_e p);
    panel_e r;
    case (p)
      CARD_BARS:  r = CARD_HATCH;
      CARD_HATCH: r = CARD_BURST;
      CARD_BURST: r = CARD_CHECK;
      CARD_CHECK: r = CARD_EDGE;
      default:    r = CARD_BARS;
    endcase
    return r;
  endfunction

  function automatic panel_e panel_prev(panel_e p);
    panel_e r;
    case (p)
      CARD_HATCH: r = CARD_BARS;
      CARD_BURST: r = CARD_HATCH;
      CARD_CHECK: r = CARD_BURST;
      CARD_EDGE:  r = CARD_CHECK;
      default:    r = CARD_EDGE;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/vtpg_if.sv
// ----------------------------------------------------------------------------
// vtpg channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface vtpg_in_if;
  logic                          valid;
  logic                          ready;
  logic [vtpg_pkg::CmdW-1:0]     cmd;
  logic [vtpg_pkg::KeysW-1:0]    keys;
  logic [vtpg_pkg::CoordW-1:0]   pix_x;
  logic [vtpg_pkg::CoordW-1:0]   pix_y;

  modport source (output valid, cmd, keys, pix_x, pix_y, input ready);
  modport sink   (input valid, cmd, keys, pix_x, pix_y, output ready);
endinterface

interface vtpg_out_if;
  logic                          valid;
  logic                          ready;
  logic [vtpg_pkg::KindW-1:0]    color_kind;
  logic [vtpg_pkg::BarW-1:0]     bar_index;
  logic [vtpg_pkg::GreyW-1:0]    gray_level;
  logic [vtpg_pkg::PanelW-1:0]   panel;
  logic                          redraw;

  modport source (output valid, color_kind, bar_index, gray_level, panel, redraw,
                  input ready);
  modport sink   (input valid, color_kind, bar_index, gray_level, panel, redraw,
                  output ready);
endinterface

>>> rtl/vtpg_pixel.sv
// ----------------------------------------------------------------------------
// vtpg_pixel
// colour classifier for one pixel: panel art, border, checker, dim row, band
// ----------------------------------------------------------------------------
module vtpg_pixel (
  input  vtpg_pkg::view_t                view_i,
  input  logic [vtpg_pkg::CoordW-1:0]    pix_x_i,
  input  logic [vtpg_pkg::CoordW-1:0]    pix_y_i,
  output vtpg_pkg::kind_e                kind_o,
  output logic [vtpg_pkg::BarW-1:0]      bar_o,
  output logic [vtpg_pkg::GreyW-1:0]     grey_o
);

  logic [15:0] div15_prod;
  logic [3:0]  col15;
  logic [25:0] ramp_prod;
  logic [4:0]  ramp_grey;
  logic [7:0]  ry;
  logic [7:0]  cross_i;
  logic [8:0]  band_p;
  logic [3:0]  x_lo;
  logic        on_screen;
  logic        in_area;

  assign div15_prod = {8'b0, pix_x_i} * {8'b0, vtpg_pkg::Div15Mul};
  assign col15      = div15_prod[14:11];
  assign ramp_prod  = {18'b0, pix_x_i} * {7'b0, vtpg_pkg::RampMul};
  assign ramp_grey  = ramp_prod[25:21];
  assign ry         = pix_y_i - vtpg_pkg::AreaTop;
  assign cross_i    = pix_y_i - vtpg_pkg::CrossTop;
  assign band_p     = {1'b0, pix_x_i} + {4'b0, view_i.frame_low};
  assign x_lo       = pix_x_i[3:0];
  assign on_screen  = (pix_x_i <= vtpg_pkg::XLast) && (pix_y_i <= vtpg_pkg::YLast);
  assign in_area    = (pix_y_i >= vtpg_pkg::AreaTop) && (pix_y_i < vtpg_pkg::AreaBot);

  always_comb begin
    kind_o = vtpg_pkg::KIND_BLACK;
    bar_o  = '0;
    grey_o = '0;
    if (on_screen) begin
      if (in_area) begin
        case (view_i.panel)
          vtpg_pkg::CARD_BARS: begin
            if (ry < vtpg_pkg::BarsRows) begin
              kind_o = vtpg_pkg::KIND_BAR;
              bar_o  = col15[3:1];
            end else begin
              // staircase, last step lifted to full white
              kind_o = vtpg_pkg::KIND_GREY;
              grey_o = {col15, &col15};
            end
          end
          vtpg_pkg::CARD_HATCH: begin
            if (x_lo == 4'd0 || pix_x_i == vtpg_pkg::XLast ||
                ry[3:0] == 4'd0 || pix_y_i == vtpg_pkg::HatchRow) begin
              kind_o = vtpg_pkg::KIND_WHITE;
            end
            if (pix_y_i >= vtpg_pkg::CrossTop && pix_y_i < vtpg_pkg::CrossEnd &&
                (pix_x_i == vtpg_pkg::CrossLeft + cross_i ||
                 pix_x_i == vtpg_pkg::CrossRite - cross_i)) begin
              kind_o = vtpg_pkg::KIND_RED;
            end
          end
          vtpg_pkg::CARD_BURST: begin
            // pitch doubles every 32 rows, last row of each group blank
            if (ry[4:0] != 5'd31 && !x_lo[ry[6:5]]) begin
              kind_o = vtpg_pkg::KIND_WHITE;
            end
          end
          vtpg_pkg::CARD_EDGE: begin
            if (!ry[6]) begin
              kind_o = vtpg_pkg::KIND_GREY;
              grey_o = ramp_grey;
            end else begin
              kind_o = (pix_x_i < vtpg_pkg::XMid) ? vtpg_pkg::KIND_BLACK
                                                 : vtpg_pkg::KIND_WHITE;
              if (pix_y_i >= vtpg_pkg::SwatchTop && pix_y_i < vtpg_pkg::SwatchEnd) begin
                if (pix_x_i >= vtpg_pkg::XHalfIn && pix_x_i < vtpg_pkg::XMid) begin
                  kind_o = vtpg_pkg::KIND_RED;
                end else if (pix_x_i >= vtpg_pkg::XMid && pix_x_i < vtpg_pkg::XHalfOut) begin
                  kind_o = vtpg_pkg::KIND_BLUE;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (pix_x_i == '0 || pix_y_i == '0 ||
          pix_x_i == vtpg_pkg::XLast || pix_y_i == vtpg_pkg::YLast) begin
        kind_o = vtpg_pkg::KIND_WHITE;
        bar_o  = '0;
        grey_o = '0;
      end

      // checker flips every frame and covers the border
      if (view_i.panel == vtpg_pkg::CARD_CHECK && in_area) begin
        kind_o = (pix_x_i[3] ^ ry[3] ^ view_i.frame_low[0]) ? vtpg_pkg::KIND_WHITE
                                                             : vtpg_pkg::KIND_BLACK;
        bar_o  = '0;
        grey_o = '0;
      end

      if (pix_y_i == vtpg_pkg::DimRow) begin
        kind_o = vtpg_pkg::KIND_DIM;
        bar_o  = '0;
        grey_o = '0;
      end

      // scrolling band of bars with white separators
      if (pix_y_i >= vtpg_pkg::BandTop && pix_y_i < vtpg_pkg::BandEnd) begin
        grey_o = '0;
        if (band_p[4:0] == 5'd0) begin
          kind_o = vtpg_pkg::KIND_WHITE;
          bar_o  = '0;
        end else begin
          kind_o = vtpg_pkg::KIND_BAR;
          bar_o  = band_p[7:5];
        end
      end
    end
  end

endmodule

>>> rtl/video_test_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// video_test_pattern_generator_core
// frame sequencer and per-pixel colour classifier for a 240x160 test card
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries requests: cmd 0 is a frame tick with the key bitmap, cmd 1
//   asks for the colour class of pixel (pix_x, pix_y). out_ch returns one
//   transaction per request, in order: colour class, bar index, grey level,
//   current panel and, for ticks, the redraw flag.
//   a request is captured in an input register, classified or applied to the
//   sequencer once the output register can take a result, and written to
//   that register, which drives out_ch. one request per cycle is sustained
//   while out_ch is ready; the classifier is a single pass of logic with
//   two constant multiplies, and the sequencer updates in the same cycle.
//   when out_ch stalls, the held result and one captured request wait and
//   in_ch.ready drops only once both are full.
//   the apb port holds panel_hold_frames at address 0; write it only while
//   no request is in flight.
//   reset: bars panel, auto mode, frame count 31, redraw pending, hold 128.
// ----------------------------------------------------------------------------
`include "video_test_pattern_generator_core_macros.svh"

module video_test_pattern_generator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  vtpg_in_if.sink                            in_ch,
  vtpg_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vtpg_pkg::PaddrW-1:0]        paddr,
  input  logic [vtpg_pkg::PdataW-1:0]        pwdata,
  output logic [vtpg_pkg::PdataW-1:0]        prdata,
  output logic                               pready
);

  // input register
  logic                              req_valid_q;
  vtpg_pkg::cmd_e                    req_cmd_q;
  logic [vtpg_pkg::KeysW-1:0]        req_keys_q;
  logic [vtpg_pkg::CoordW-1:0]       req_x_q;
  logic [vtpg_pkg::CoordW-1:0]       req_y_q;

  // result register
  logic                              res_valid_q;
  vtpg_pkg::kind_e                   res_kind_q;
  logic [vtpg_pkg::BarW-1:0]         res_bar_q;
  logic [vtpg_pkg::GreyW-1:0]        res_grey_q;
  vtpg_pkg::panel_e                  res_panel_q;
  logic                              res_redraw_q;

  // sequencer state
  logic [vtpg_pkg::HoldW-1:0]        hold_frames_q;
  vtpg_pkg::panel_e                  panel_sel_q, panel_sel_d;
  logic [vtpg_pkg::HoldW-1:0]        hold_count_q, hold_count_d;
  logic                              manual_q, manual_d;
  logic [vtpg_pkg::KeysW-1:0]        last_keys_q;
  logic [vtpg_pkg::FrameW-1:0]       frame_low_q;
  logic                              redraw_pend_q;

  logic                              in_acc;
  logic                              res_adv;
  logic                              proc;
  logic                              tick_fire;
  logic                              cfg_wr;
  logic [vtpg_pkg::KeysW-1:0]        hit;
  logic                              step_fwd;
  logic                              step_back;
  logic                              step_auto;
  logic [vtpg_pkg::HoldW-1:0]        hold_inc;
  vtpg_pkg::panel_e                  panel_man;
  vtpg_pkg::view_t                   view;
  vtpg_pkg::kind_e                   px_kind;
  logic [vtpg_pkg::BarW-1:0]         px_bar;
  logic [vtpg_pkg::GreyW-1:0]        px_grey;

  // handshakes
  assign res_adv      = !res_valid_q || out_ch.ready;
  assign proc         = req_valid_q && res_adv;
  assign in_ch.ready  = !req_valid_q || res_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign tick_fire    = proc && (req_cmd_q == vtpg_pkg::CMD_TICK);

  assign cfg_wr  = psel && penable && pwrite && (paddr == vtpg_pkg::AddrPanelHold);
  assign pready  = 1'b1;
  assign prdata  = (paddr == vtpg_pkg::AddrPanelHold)
                   ? {{(vtpg_pkg::PdataW - vtpg_pkg::HoldW){1'b0}}, hold_frames_q}
                   : '0;

  // tick: key edges first, then automatic advance outside manual mode
  assign hit       = req_keys_q & ~last_keys_q;
  assign step_fwd  = |(hit & vtpg_pkg::KeysFwd);
  assign step_back = |(hit & vtpg_pkg::KeysBack);
  assign hold_inc  = hold_count_q + 8'd1;

  always_comb begin
    panel_man = panel_sel_q;
    if (step_fwd) begin
      panel_man = vtpg_pkg::panel_next(panel_man);
    end
    if (step_back) begin
      panel_man = vtpg_pkg::panel_prev(panel_man);
    end
    manual_d = manual_q | step_fwd | step_back;
    if (hit[vtpg_pkg::KeyStart]) begin
      manual_d = 1'b0;
    end
    step_auto    = 1'b0;
    hold_count_d = hold_count_q;
    panel_sel_d  = panel_man;
    if (!manual_d) begin
      hold_count_d = hold_inc;
      if (hold_inc >= hold_frames_q) begin
        hold_count_d = '0;
        step_auto    = 1'b1;
        panel_sel_d  = vtpg_pkg::panel_next(panel_man);
      end
    end
  end

  assign view.panel     = panel_sel_q;
  assign view.frame_low = frame_low_q;

  vtpg_pixel u_pixel (
    .view_i  (view),
    .pix_x_i (req_x_q),
    .pix_y_i (req_y_q),
    .kind_o  (px_kind),
    .bar_o   (px_bar),
    .grey_o  (px_grey)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q   <= 1'b0;
      res_valid_q   <= 1'b0;
      hold_frames_q <= vtpg_pkg::HoldReset;
      panel_sel_q   <= vtpg_pkg::CARD_BARS;
      hold_count_q  <= '0;
      manual_q      <= 1'b0;
      last_keys_q   <= '0;
      frame_low_q   <= '1;
      redraw_pend_q <= 1'b1;
    end else begin
      if (in_acc) begin
        req_valid_q <= 1'b1;
      end else if (proc) begin
        req_valid_q <= 1'b0;
      end
      if (proc) begin
        res_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        hold_frames_q <= pwdata[vtpg_pkg::HoldW-1:0];
      end
      if (tick_fire) begin
        panel_sel_q   <= panel_sel_d;
        hold_count_q  <= hold_count_d;
        manual_q      <= manual_d;
        last_keys_q   <= req_keys_q;
        frame_low_q   <= frame_low_q + 5'd1;
        redraw_pend_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_cmd_q  <= vtpg_pkg::cmd_e'(in_ch.cmd);
      req_keys_q <= in_ch.keys;
      req_x_q    <= in_ch.pix_x;
      req_y_q    <= in_ch.pix_y;
    end
    if (proc) begin
      if (req_cmd_q == vtpg_pkg::CMD_TICK) begin
        res_kind_q   <= vtpg_pkg::KIND_BLACK;
        res_bar_q    <= '0;
        res_grey_q   <= '0;
        res_panel_q  <= panel_sel_d;
        res_redraw_q <= redraw_pend_q | step_fwd | step_back | step_auto;
      end else begin
        res_kind_q   <= px_kind;
        res_bar_q    <= px_bar;
        res_grey_q   <= px_grey;
        res_panel_q  <= panel_sel_q;
        res_redraw_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = res_valid_q;
  assign out_ch.color_kind = res_kind_q;
  assign out_ch.bar_index  = res_bar_q;
  assign out_ch.gray_level = res_grey_q;
  assign out_ch.panel      = res_panel_q;
  assign out_ch.redraw     = res_redraw_q;

  `VTPG_ASSERT_SAME(a_panel_range, out_ch.valid, out_ch.panel <= vtpg_pkg::CARD_EDGE)
  `VTPG_ASSERT_SAME(a_redraw_tick_only, out_ch.valid && out_ch.redraw,
                    out_ch.color_kind == vtpg_pkg::KIND_BLACK && out_ch.gray_level == '0)
  `VTPG_ASSERT_NEXT(a_panel_hold, !tick_fire, $stable(panel_sel_q) && $stable(frame_low_q))
  `VTPG_ASSERT_NEXT(a_result_follows, proc, out_ch.valid)

endmodule

>>> test/video_test_pattern_generator_core_tb.sv
// ----------------------------------------------------------------------------
// video_test_pattern_generator_core_tb
// self-checking bench for the test card core: frame ticks with key presses
// and pixel requests go in over in_ch. an in-bench model of the panel
// sequencer and the pixel classifier predicts every result. out_ch
// transactions are compared in order, field by field. the hold register is
// rewritten between phases, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module video_test_pattern_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // picture geometry of the card
  localparam int unsigned CardW      = 240;
  localparam int unsigned CardH      = 160;
  localparam int unsigned PanelTop   = 8;
  localparam int unsigned PanelBot   = 136;
  localparam int unsigned BarRows    = 90;
  localparam int unsigned BurstRows  = 32;
  localparam int unsigned RampRows   = 64;
  localparam int unsigned CrossRow0  = 48;
  localparam int unsigned CrossRows  = 24;
  localparam int unsigned CenterX    = 120;
  localparam int unsigned SwatchRow0 = 116;
  localparam int unsigned SwatchRow1 = 134;
  localparam int unsigned SwatchW    = 40;
  localparam int unsigned DimLine    = 137;
  localparam int unsigned BandFirst  = 138;
  localparam int unsigned BandLen    = 12;
  localparam int unsigned NumPanels  = 5;

  typedef logic [vtpg_pkg::KeysW-1:0] keys_t;

  // key bits
  localparam keys_t KbA     = 7'h01;
  localparam keys_t KbB     = 7'h02;
  localparam keys_t KbLeft  = 7'h04;
  localparam keys_t KbRight = 7'h08;
  localparam keys_t KbL     = 7'h10;
  localparam keys_t KbR     = 7'h20;
  localparam keys_t KbStart = 7'h40;
  localparam keys_t StepFwdMask  = KbA | KbRight | KbR;
  localparam keys_t StepBackMask = KbB | KbLeft | KbL;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 230;
  localparam int StallLen      = 80;
  localparam int WatchdogLimit = 5000;

  typedef struct {
    vtpg_pkg::cmd_e                  cmd;
    keys_t                           keys;
    logic [vtpg_pkg::CoordW-1:0]     pix_x;
    logic [vtpg_pkg::CoordW-1:0]     pix_y;
  } req_t;

  typedef struct {
    logic [vtpg_pkg::KindW-1:0]      color_kind;
    logic [vtpg_pkg::BarW-1:0]       bar_index;
    logic [vtpg_pkg::GreyW-1:0]      gray_level;
    logic [vtpg_pkg::PanelW-1:0]     panel;
    logic                            redraw;
  } res_t;

  class card_scoreboard;
    res_t                            pending_results[$];
    logic [vtpg_pkg::HoldW-1:0]      hold_frames;
    vtpg_pkg::panel_e                panel_sel;
    logic [vtpg_pkg::HoldW-1:0]      hold_count;
    logic                            manual;
    keys_t                           last_keys;
    logic [vtpg_pkg::FrameW-1:0]     frame_low;
    logic                            redraw_pending;
    int                              n_errors;
    int                              n_checked;

    function new();
      hold_frames    = 8'd128;
      panel_sel      = vtpg_pkg::CARD_BARS;
      hold_count     = '0;
      manual         = 1'b0;
      last_keys      = '0;
      frame_low      = 5'd31;
      redraw_pending = 1'b1;
      n_errors       = 0;
      n_checked      = 0;
    endfunction

    function void set_hold(logic [vtpg_pkg::HoldW-1:0] v);
      hold_frames = v;
    endfunction

    function vtpg_pkg::panel_e step_panel(vtpg_pkg::panel_e p, bit fwd);
      int unsigned n;
      n = int'(p);
      n = fwd ? (n + 1) % NumPanels : (n + NumPanels - 1) % NumPanels;
      return vtpg_pkg::panel_e'(n);
    endfunction

    function res_t advance_frame(keys_t keys);
      keys_t hit;
      res_t  r;
      hit       = keys & ~last_keys;
      last_keys = keys;
      frame_low = frame_low + 1'b1;
      if (|(hit & StepFwdMask)) begin
        panel_sel      = step_panel(panel_sel, 1'b1);
        redraw_pending = 1'b1;
        manual         = 1'b1;
      end
      if (|(hit & StepBackMask)) begin
        panel_sel      = step_panel(panel_sel, 1'b0);
        redraw_pending = 1'b1;
        manual         = 1'b1;
      end
      if (|(hit & KbStart)) manual = 1'b0;
      if (!manual) begin
        hold_count = hold_count + 1'b1;
        if (hold_count >= hold_frames) begin
          hold_count     = '0;
          panel_sel      = step_panel(panel_sel, 1'b1);
          redraw_pending = 1'b1;
        end
      end
      r.color_kind   = vtpg_pkg::KIND_BLACK;
      r.bar_index    = '0;
      r.gray_level   = '0;
      r.panel        = panel_sel;
      r.redraw       = redraw_pending;
      redraw_pending = 1'b0;
      return r;
    endfunction

    function res_t classify_pixel(int unsigned x, int unsigned y);
      res_t            r;
      vtpg_pkg::kind_e k;
      int unsigned     bar, grey, ry, i, pitch, p;
      k    = vtpg_pkg::KIND_BLACK;
      bar  = 0;
      grey = 0;
      if (x < CardW && y < CardH) begin
        ry = y - PanelTop;
        if (y >= PanelTop && y < PanelBot) begin
          case (panel_sel)
            vtpg_pkg::CARD_BARS: begin
              if (ry < BarRows) begin
                k   = vtpg_pkg::KIND_BAR;
                bar = x / 30;
              end else begin
                // staircase: 16 steps, the last one brightened to full scale
                i    = x / 15;
                k    = vtpg_pkg::KIND_GREY;
                grey = i * 2 + ((i == 15) ? 1 : 0);
              end
            end
            vtpg_pkg::CARD_HATCH: begin
              if (x % 16 == 0 || x == CardW - 1 || ry % 16 == 0 || y == PanelBot - 1)
                k = vtpg_pkg::KIND_WHITE;
              if (y >= CrossRow0 && y < CrossRow0 + CrossRows) begin
                i = y - CrossRow0;
                if (x == CenterX - CrossRows + i || x == CenterX + CrossRows - i)
                  k = vtpg_pkg::KIND_RED;
              end
            end
            vtpg_pkg::CARD_BURST: begin
              pitch = 2 << (ry / BurstRows);
              k = (ry % BurstRows < BurstRows - 1 && x % pitch < pitch / 2) ?
                  vtpg_pkg::KIND_WHITE : vtpg_pkg::KIND_BLACK;
            end
            vtpg_pkg::CARD_EDGE: begin
              if (ry < RampRows) begin
                k    = vtpg_pkg::KIND_GREY;
                grey = (x * 31) / (CardW - 1);
              end else begin
                k = (x < CenterX) ? vtpg_pkg::KIND_BLACK : vtpg_pkg::KIND_WHITE;
                if (y >= SwatchRow0 && y < SwatchRow1) begin
                  if (x >= CenterX - SwatchW && x < CenterX) k = vtpg_pkg::KIND_RED;
                  else if (x >= CenterX && x < CenterX + SwatchW) k = vtpg_pkg::KIND_BLUE;
                end
              end
            end
            default: ;
          endcase
        end
        if (x == 0 || y == 0 || x == CardW - 1 || y == CardH - 1) k = vtpg_pkg::KIND_WHITE;
        // checkerboard flips every frame and covers the border
        if (panel_sel == vtpg_pkg::CARD_CHECK && y >= PanelTop && y < PanelBot)
          k = (((x >> 3) ^ (ry / 8) ^ frame_low) & 1) ? vtpg_pkg::KIND_WHITE
                                                      : vtpg_pkg::KIND_BLACK;
        if (y == DimLine) k = vtpg_pkg::KIND_DIM;
        if (y >= BandFirst && y < BandFirst + BandLen) begin
          p = x + frame_low;
          if (p % 32 == 0) begin
            k = vtpg_pkg::KIND_WHITE;
          end else begin
            k   = vtpg_pkg::KIND_BAR;
            bar = (p / 32) & 7;
          end
        end
      end
      r.color_kind = k;
      r.bar_index  = (k == vtpg_pkg::KIND_BAR) ? 3'(bar) : '0;
      r.gray_level = (k == vtpg_pkg::KIND_GREY) ? 5'(grey) : '0;
      r.panel      = panel_sel;
      r.redraw     = 1'b0;
      return r;
    endfunction

    function void note_input(req_t q);
      if (q.cmd == vtpg_pkg::CMD_TICK) pending_results.push_back(advance_frame(q.keys));
      else pending_results.push_back(classify_pixel(q.pix_x, q.pix_y));
    endfunction

    function void check_result(res_t got);
      res_t exp;
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.color_kind !== exp.color_kind) begin
        $error("color_kind: expected %0d, got %0d", exp.color_kind, got.color_kind);
        n_errors++;
      end
      if (got.bar_index !== exp.bar_index) begin
        $error("bar_index: expected %0d, got %0d", exp.bar_index, got.bar_index);
        n_errors++;
      end
      if (got.gray_level !== exp.gray_level) begin
        $error("gray_level: expected %0d, got %0d", exp.gray_level, got.gray_level);
        n_errors++;
      end
      if (got.panel !== exp.panel) begin
        $error("panel: expected %0d, got %0d", exp.panel, got.panel);
        n_errors++;
      end
      if (got.redraw !== exp.redraw) begin
        $error("redraw: expected %0d, got %0d", exp.redraw, got.redraw);
        n_errors++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [vtpg_pkg::PaddrW-1:0]       paddr;
  logic [vtpg_pkg::PdataW-1:0]       pwdata;
  logic [vtpg_pkg::PdataW-1:0]       prdata;
  logic                              pready;

  vtpg_in_if  in_ch();
  vtpg_out_if out_ch();

  card_scoreboard sb = new();

  bit    quiet;
  bit    src_gaps_on;
  bit    stall_done;
  keys_t keys_sent;
  int    hold_plan[NumPhases] = '{0, 1, 255, 5, 0, 2, 12, 1};

  video_test_pattern_generator_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic req_t mk_tick(keys_t keys);
    req_t q;
    q.cmd   = vtpg_pkg::CMD_TICK;
    q.keys  = keys;
    q.pix_x = 8'($urandom());
    q.pix_y = 8'($urandom());
    return q;
  endfunction

  function automatic req_t mk_pixel(int unsigned x, int unsigned y);
    req_t q;
    q.cmd   = vtpg_pkg::CMD_PIXEL;
    q.keys  = 7'($urandom());
    q.pix_x = 8'(x);
    q.pix_y = 8'(y);
    return q;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(req_t q);
    in_ch.valid = 1'b1;
    in_ch.cmd   = q.cmd;
    in_ch.keys  = q.keys;
    in_ch.pix_x = q.pix_x;
    in_ch.pix_y = q.pix_y;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(q);
    if (q.cmd == vtpg_pkg::CMD_TICK) keys_sent = q.keys;
    @(negedge clk_i);
  endtask

  task automatic src_gap(int n);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // write the hold register, then read it back
  task automatic write_hold(logic [vtpg_pkg::HoldW-1:0] v);
    logic [vtpg_pkg::PdataW-1:0] wd;
    wd                      = $urandom();
    wd[vtpg_pkg::HoldW-1:0] = v;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = vtpg_pkg::AddrPanelHold;
    pwdata  = wd;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_hold(v);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[vtpg_pkg::HoldW-1:0] !== v) begin
      $error("panel_hold_frames: expected %0d, got %0d", v, prdata[vtpg_pkg::HoldW-1:0]);
      sb.n_errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic req_t random_item();
    int unsigned sel, y;
    keys_t       k;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = keys_sent;                                 // held, no new press
        4, 5:       k = '0;                                        // release
        6:          k = keys_sent | 7'(1 << $urandom_range(0, 5));
        7:          k = KbStart;
        default:    k = 7'($urandom_range(0, 127));
      endcase
      return mk_tick(k);
    end
    case ($urandom_range(0, 9))
      0:       return mk_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      1, 2:    return mk_pixel($urandom_range(0, CardW - 1),
                               $urandom_range(PanelBot, BandFirst + BandLen));
      3: begin
        // hug the red cross of the hatch panel
        y = $urandom_range(CrossRow0, CrossRow0 + CrossRows - 1);
        if ($urandom_range(0, 1))
          return mk_pixel(CenterX - CrossRows + (y - CrossRow0) + $urandom_range(0, 1), y);
        return mk_pixel(CenterX + CrossRows - (y - CrossRow0) - $urandom_range(0, 1), y);
      end
      default: return mk_pixel($urandom_range(0, CardW - 1), $urandom_range(0, CardH - 1));
    endcase
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    int stall_cnt;
    stall_cnt    = 0;
    stall_done   = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!stall_done && sb.n_checked >= 300) begin
        stall_done = 1'b1;
        stall_cnt  = StallLen;
      end
      if (stall_cnt > 0) begin
        out_ch.ready = 1'b0;
        stall_cnt--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        stall_cnt    = $urandom_range(1, 16) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.color_kind = out_ch.color_kind;
      got.bar_index  = out_ch.bar_index;
      got.gray_level = out_ch.gray_level;
      got.panel      = out_ch.panel;
      got.redraw     = out_ch.redraw;
      sb.check_result(got);
    end
  end

  // watchdog: cycles without any transaction or register access
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    req_t directed[$];
    in_ch.valid = 1'b0;
    in_ch.cmd   = vtpg_pkg::CMD_TICK;
    in_ch.keys  = '0;
    in_ch.pix_x = '0;
    in_ch.pix_y = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    quiet       = 1'b0;
    src_gaps_on = 1'b1;
    keys_sent   = '0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // pixels before the first tick see frame count 31
    directed.push_back(mk_pixel(5, 140));
    directed.push_back(mk_pixel(0, 0));
    directed.push_back(mk_pixel(239, 159));
    directed.push_back(mk_pixel(255, 255));
    directed.push_back(mk_pixel(240, 10));
    directed.push_back(mk_pixel(10, 160));
    directed.push_back(mk_tick('0));                    // first frame redraw
    directed.push_back(mk_pixel(29, 50));
    directed.push_back(mk_pixel(225, 120));             // top stair step
    directed.push_back(mk_pixel(50, 137));
    directed.push_back(mk_tick(KbRight));
    directed.push_back(mk_pixel(96, 48));
    directed.push_back(mk_pixel(121, 71));
    directed.push_back(mk_tick(KbA | KbB));             // forward and back together
    directed.push_back(mk_tick(KbRight));
    directed.push_back(mk_pixel(2, 9));
    directed.push_back(mk_tick(KbR));
    directed.push_back(mk_pixel(0, 8));
    directed.push_back(mk_tick(KbA));
    directed.push_back(mk_pixel(239, 40));
    directed.push_back(mk_pixel(100, 120));
    directed.push_back(mk_pixel(130, 120));
    directed.push_back(mk_tick(KbStart));
    directed.push_back(mk_tick(7'h7f));
    directed.push_back(mk_tick('0));
    foreach (directed[i]) begin
      if ($urandom_range(0, 3) == 0) src_gap($urandom_range(1, 16));
      send_item(directed[i]);
    end
    drain();

    hold_plan[4] = $urandom_range(2, 30);
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_hold(8'(hold_plan[ph]));
      quiet       = (ph == NumPhases - 1);
      src_gaps_on = (ph % 3 != 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (!quiet && src_gaps_on && $urandom_range(0, 5) == 0)
          src_gap($urandom_range(1, 16));
        send_item(random_item());
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.n_errors++;
    end
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
